// ===== rtl/anjn_pkg.sv =====
`timescale 1ns / 1ps

package anjn_pkg;

    localparam int MAX_ITEMS = 5;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W     = $clog2(MAX_ITEMS);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_UC_E  = 8'h45;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_F     = 8'h66;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_mark;
        logic       failed;
    } item_t;

    typedef struct packed {
        item_t [MAX_ITEMS-1:0] items;
        logic  [CNT_W-1:0]     count;
    } burst_t;

endpackage

// ===== rtl/anjn_in_if.sv =====
`timescale 1ns / 1ps

interface anjn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_in;

    modport source (output valid, output in_byte, output last_in, input ready);
    modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

// ===== rtl/anjn_out_if.sv =====
`timescale 1ns / 1ps

interface anjn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_mark;
    logic       failed;

    modport source (output valid, output out_byte, output end_mark, output failed,
                    input ready);
    modport sink   (input valid, input out_byte, input end_mark, input failed,
                    output ready);
endinterface

// ===== rtl/anjn_parse.sv =====
`timescale 1ns / 1ps

module anjn_parse (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      in_byte,
    input  logic            last_in,
    output anjn_pkg::burst_t burst
);
    import anjn_pkg::*;

    typedef enum logic [3:0] {
        PH_START = 4'd0,
        PH_SIGN  = 4'd1,
        PH_INF1  = 4'd2,
        PH_INF2  = 4'd3,
        PH_ZEROS = 4'd4,
        PH_LDOT  = 4'd5,
        PH_DIG   = 4'd6,
        PH_DOT   = 4'd7,
        PH_EXP   = 4'd8,
        PH_ESIGN = 4'd9,
        PH_EDIG  = 4'd10,
        PH_DONE  = 4'd11
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic       sld_reg, sld_next;
    logic       wrote_reg, wrote_next;
    logic       fail_reg, fail_next;

    item_t [MAX_ITEMS-1:0] items;
    logic  [CNT_W-1:0]     n;
    logic                  is_dig;
    logic                  is_e;
    logic                  bad;

    function automatic item_t chr(input logic [7:0] b);
        item_t it;
        it.out_byte = b;
        it.end_mark = 1'b0;
        it.failed   = 1'b0;
        return it;
    endfunction

    always_comb
    begin
        items      = '0;
        n          = '0;
        phase_next = phase_reg;
        sld_next   = sld_reg;
        wrote_next = wrote_reg;
        fail_next  = fail_reg;
        bad        = 1'b0;
        is_dig     = in_byte inside {[CH_0:CH_9]};
        is_e       = (in_byte == CH_LC_E) || (in_byte == CH_UC_E);

        case (phase_reg)
            PH_START, PH_SIGN:
            begin
                if (phase_reg == PH_START && in_byte == CH_MINUS)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                    phase_next = PH_SIGN;
                end
                else if (in_byte == CH_I)
                    phase_next = PH_INF1;
                else if (in_byte == CH_0)
                    phase_next = PH_ZEROS;
                else if (in_byte == CH_DOT)
                begin
                    items[n] = chr(CH_0); n = n + 1'b1;
                    items[n] = chr(CH_DOT); n = n + 1'b1;
                    sld_next   = 1'b1;
                    phase_next = PH_LDOT;
                end
                else if (is_dig)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                    phase_next = PH_DIG;
                end
                else if (is_e)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                    phase_next = PH_EXP;
                end
                else
                    phase_next = PH_DONE;
            end
            PH_INF1:
            begin
                if (in_byte == CH_N)
                    phase_next = PH_INF2;
                else
                begin
                    fail_next  = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_INF2:
            begin
                if (in_byte == CH_F)
                begin
                    items[n] = chr(CH_1); n = n + 1'b1;
                    items[n] = chr(CH_LC_E); n = n + 1'b1;
                    items[n] = chr(CH_9); n = n + 1'b1;
                    items[n] = chr(CH_9); n = n + 1'b1;
                end
                else
                    fail_next = 1'b1;
                phase_next = PH_DONE;
            end
            PH_ZEROS:
            begin
                if (in_byte == CH_0)
                    phase_next = PH_ZEROS;
                else if (in_byte == CH_DOT)
                begin
                    items[n] = chr(CH_0); n = n + 1'b1;
                    items[n] = chr(CH_DOT); n = n + 1'b1;
                    sld_next   = 1'b1;
                    phase_next = PH_LDOT;
                end
                else if (is_dig)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                    phase_next = PH_DIG;
                end
                else
                begin
                    items[n] = chr(CH_0); n = n + 1'b1;
                    if (is_e)
                    begin
                        items[n] = chr(in_byte); n = n + 1'b1;
                        phase_next = PH_EXP;
                    end
                    else
                        phase_next = PH_DONE;
                end
            end
            PH_LDOT, PH_DOT:
            begin
                if (is_dig)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                    phase_next = PH_DIG;
                end
                else
                begin
                    items[n] = chr(CH_0); n = n + 1'b1;
                    if (is_e)
                    begin
                        items[n] = chr(in_byte); n = n + 1'b1;
                        phase_next = PH_EXP;
                    end
                    else
                        phase_next = PH_DONE;
                end
            end
            PH_DIG:
            begin
                if (is_dig)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                end
                else if (in_byte == CH_DOT)
                begin
                    if (sld_reg)
                        phase_next = PH_DONE;
                    else
                    begin
                        items[n] = chr(in_byte); n = n + 1'b1;
                        sld_next   = 1'b1;
                        phase_next = PH_DOT;
                    end
                end
                else if (is_e)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                    phase_next = PH_EXP;
                end
                else
                    phase_next = PH_DONE;
            end
            PH_EXP, PH_ESIGN:
            begin
                if (phase_reg == PH_EXP && (in_byte == CH_MINUS || in_byte == CH_PLUS))
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                    phase_next = PH_ESIGN;
                end
                else if (is_dig)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                    phase_next = PH_EDIG;
                end
                else
                begin
                    items[n] = chr(CH_0); n = n + 1'b1;
                    phase_next = PH_DONE;
                end
            end
            PH_EDIG:
            begin
                if (is_dig)
                begin
                    items[n] = chr(in_byte); n = n + 1'b1;
                end
                else
                    phase_next = PH_DONE;
            end
            default:
                phase_next = PH_DONE;
        endcase

        if (n != '0)
            wrote_next = 1'b1;

        if (last_in)
        begin
            bad = fail_next;
            case (phase_next)
                PH_SIGN, PH_INF1, PH_INF2:
                    bad = 1'b1;
                PH_ZEROS, PH_LDOT, PH_DOT, PH_EXP, PH_ESIGN:
                begin
                    items[n] = chr(CH_0); n = n + 1'b1;
                    wrote_next = 1'b1;
                end
                default:
                    ;
            endcase
            if (!wrote_next)
                bad = 1'b1;
            items[n].out_byte = 8'h00;
            items[n].end_mark = 1'b1;
            items[n].failed   = bad;
            n = n + 1'b1;
            phase_next = PH_START;
            sld_next   = 1'b0;
            wrote_next = 1'b0;
            fail_next  = 1'b0;
        end

        burst.items = items;
        burst.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            sld_reg   <= 1'b0;
            wrote_reg <= 1'b0;
            fail_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            sld_reg   <= sld_next;
            wrote_reg <= wrote_next;
            fail_reg  <= fail_next;
        end
    end

endmodule

// ===== rtl/ascii_number_to_json_normalizer.sv =====
`timescale 1ns / 1ps
// ASCII number to JSON normalizer.
// text: input channel, one character per transaction (in_byte), last_in on
//       the final character of a number.
// json: output channel, one character per transaction (out_byte); a number's
//       run closes with an end_mark transaction whose failed bit says the run
//       must be discarded.
// Each input transaction yields 0 to 5 output transactions. They are loaded
// into a result buffer at the accepting edge; the first is visible on json the
// next cycle, then one per cycle while json.ready is high.
// A new character is taken when the buffer is empty or holds its last entry
// and that entry leaves in the same cycle, so a one-to-one stream runs at one
// character per cycle. A burst of k outputs holds text off until its last output is leaving.
// When json stalls, the buffer holds and text.ready drops until it drains.
// Reset empties the buffer and returns the parser to the start of a number.
module ascii_number_to_json_normalizer (
    input  logic       clk,
    input  logic       rst_n,
    anjn_in_if.sink    text,
    anjn_out_if.source json
);
    import anjn_pkg::*;

    burst_t               burst;
    logic                 accept;
    logic                 pop;
    item_t [MAX_ITEMS-1:0] buf_reg;
    logic  [CNT_W-1:0]     cnt_reg;
    logic  [IDX_W-1:0]     rd_reg;
    item_t                 head;

    assign pop        = (cnt_reg != '0) && json.ready;
    assign text.ready = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && json.ready);
    assign accept     = text.valid && text.ready;

    anjn_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (text.in_byte),
        .last_in (text.last_in),
        .burst   (burst)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end
        else if (accept)
        begin
            cnt_reg <= burst.count;
            rd_reg  <= '0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            rd_reg  <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            buf_reg <= burst.items;
    end

    assign head          = buf_reg[rd_reg];
    assign json.valid    = (cnt_reg != '0);
    assign json.out_byte = head.out_byte;
    assign json.end_mark = head.end_mark;
    assign json.failed   = head.failed;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import anjn_pkg::*;

    localparam int RESET_CYCLES = 10;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum logic [3:0] {
        P_START, P_SIGN, P_INF1, P_INF2, P_ZEROS, P_LDOT,
        P_DIG, P_DOT, P_EXP, P_ESIGN, P_EDIG, P_DONE
    } parse_phase_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    typedef enum int {
        SH_INF, SH_ZEROS_DIGITS, SH_DIGITS, SH_FRACTION, SH_LEADING_DOT, SH_ZEROS
    } shape_t;

    logic clk;
    logic rst_n;

    anjn_in_if  text ();
    anjn_out_if json ();

    ascii_number_to_json_normalizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text.sink),
        .json  (json.source)
    );

    // predictor state
    parse_phase_t pphase;
    logic         dot_taken;
    logic         emitted_any;
    logic         rejected;
    item_t        expected_json[$];

    int           json_errors = 0;
    int           chars_sent  = 0;
    int           cycle_count = 0;
    int           burst_left  = 0;
    bit           gaps_on     = 1'b1;
    bit           hold_request = 1'b0;
    logic [7:0]   number_text[$];

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic bit is_dig(logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function void clear_parser();
        pphase      = P_START;
        dot_taken   = 1'b0;
        emitted_any = 1'b0;
        rejected    = 1'b0;
    endfunction

    function void emit_char(logic [7:0] c);
        item_t it;
        it.out_byte = c;
        it.end_mark = 1'b0;
        it.failed   = 1'b0;
        expected_json.push_back(it);
        emitted_any = 1'b1;
    endfunction

    function void try_exponent(logic [7:0] c);
        if (c == CH_LC_E || c == CH_UC_E)
        begin
            emit_char(c);
            pphase = P_EXP;
        end
        else
            pphase = P_DONE;
    endfunction

    function void take_first(logic [7:0] c);
        if (c == CH_I)
            pphase = P_INF1;
        else if (c == CH_0)
            pphase = P_ZEROS;
        else if (c == CH_DOT)
        begin
            emit_char(CH_0);
            emit_char(CH_DOT);
            dot_taken = 1'b1;
            pphase = P_LDOT;
        end
        else if (is_dig(c))
        begin
            emit_char(c);
            pphase = P_DIG;
        end
        else
            try_exponent(c);
    endfunction

    function void need_exp_digit(logic [7:0] c);
        if (is_dig(c))
        begin
            emit_char(c);
            pphase = P_EDIG;
        end
        else
        begin
            emit_char(CH_0);
            pphase = P_DONE;
        end
    endfunction

    function void normalize_char(logic [7:0] c, logic last);
        item_t closing;
        logic  bad;
        case (pphase)
            P_START:
                if (c == CH_MINUS)
                begin
                    emit_char(c);
                    pphase = P_SIGN;
                end
                else
                    take_first(c);
            P_SIGN:
                take_first(c);
            P_INF1:
                if (c == CH_N)
                    pphase = P_INF2;
                else
                begin
                    rejected = 1'b1;
                    pphase = P_DONE;
                end
            P_INF2:
            begin
                if (c == CH_F)
                begin
                    emit_char(CH_1);
                    emit_char(CH_LC_E);
                    emit_char(CH_9);
                    emit_char(CH_9);
                end
                else
                    rejected = 1'b1;
                pphase = P_DONE;
            end
            P_ZEROS:
                if (c != CH_0)
                begin
                    if (c == CH_DOT)
                    begin
                        emit_char(CH_0);
                        emit_char(CH_DOT);
                        dot_taken = 1'b1;
                        pphase = P_LDOT;
                    end
                    else if (is_dig(c))
                    begin
                        emit_char(c);
                        pphase = P_DIG;
                    end
                    else
                    begin
                        emit_char(CH_0);
                        try_exponent(c);
                    end
                end
            P_LDOT, P_DOT:
                if (is_dig(c))
                begin
                    emit_char(c);
                    pphase = P_DIG;
                end
                else
                begin
                    emit_char(CH_0);
                    if (c == CH_DOT)
                        pphase = P_DONE;
                    else
                        try_exponent(c);
                end
            P_DIG:
                if (is_dig(c))
                    emit_char(c);
                else if (c == CH_DOT)
                begin
                    if (dot_taken)
                        pphase = P_DONE;
                    else
                    begin
                        emit_char(c);
                        dot_taken = 1'b1;
                        pphase = P_DOT;
                    end
                end
                else
                    try_exponent(c);
            P_EXP:
                if (c == CH_MINUS || c == CH_PLUS)
                begin
                    emit_char(c);
                    pphase = P_ESIGN;
                end
                else
                    need_exp_digit(c);
            P_ESIGN:
                need_exp_digit(c);
            P_EDIG:
                if (is_dig(c))
                    emit_char(c);
                else
                    pphase = P_DONE;
            default:
                pphase = P_DONE;
        endcase

        if (last)
        begin
            bad = rejected;
            case (pphase)
                P_SIGN, P_INF1, P_INF2:
                    bad = 1'b1;
                P_ZEROS, P_LDOT, P_DOT, P_EXP, P_ESIGN:
                    emit_char(CH_0);
                default:
                    ;
            endcase
            if (!emitted_any)
                bad = 1'b1;
            closing.out_byte = 8'h00;
            closing.end_mark = 1'b1;
            closing.failed   = bad;
            expected_json.push_back(closing);
            clear_parser();
        end
    endfunction

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin
        item_t want;
        if (rst_n && json.valid && json.ready)
        begin
            if (expected_json.size() == 0)
            begin
                $display("%0t: unexpected transaction: out_byte %h end_mark %b failed %b",
                         $time, json.out_byte, json.end_mark, json.failed);
                json_errors = json_errors + 1;
            end
            else
            begin
                want = expected_json.pop_front();
                if (json.end_mark !== want.end_mark)
                begin
                    $display("%0t: end_mark expected %b actual %b",
                             $time, want.end_mark, json.end_mark);
                    json_errors = json_errors + 1;
                end
                if (json.failed !== want.failed)
                begin
                    $display("%0t: failed expected %b actual %b",
                             $time, want.failed, json.failed);
                    json_errors = json_errors + 1;
                end
                // out_byte carries no meaning on the closing transaction
                if (!want.end_mark && json.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, json.out_byte);
                    json_errors = json_errors + 1;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    initial begin
        rx_mode_t rx_mode;
        int       rx_stretch;
        int       rx_tick;
        rx_mode    = RX_OPEN;
        rx_stretch = 0;
        rx_tick    = 0;
        json.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                json.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (rx_stretch == 0)
                begin
                    rx_mode    = rx_mode_t'($urandom_range(0, 3));
                    rx_stretch = $urandom_range(10, 80);
                end
                rx_stretch = rx_stretch - 1;
                rx_tick    = rx_tick + 1;
                case (rx_mode)
                    RX_OPEN:     json.ready <= 1'b1;
                    RX_COIN:     json.ready <= $urandom_range(0, 1);
                    RX_PERIODIC: json.ready <= (rx_tick % 4) != 0;
                    default:     json.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // ---------------- sender ----------------

    task send_char(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                text.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        text.valid   <= 1'b1;
        text.in_byte <= c;
        text.last_in <= last;
        do
            @(posedge clk);
        while (!text.ready);
        normalize_char(c, last);
        burst_left = burst_left - 1;
        chars_sent = chars_sent + 1;
    endtask

    task send_number();
        for (int i = 0; i < number_text.size(); i++)
            send_char(number_text[i], i == number_text.size() - 1);
    endtask

    task send_string(input string s);
        number_text.delete();
        for (int i = 0; i < s.len(); i++)
            number_text.push_back(s[i]);
        send_number();
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function void push_digits(int n);
        for (int i = 0; i < n; i++)
            number_text.push_back(rand_digit());
    endfunction

    function void build_wellformed();
        shape_t shape;
        number_text.delete();
        if ($urandom_range(0, 2) == 0)
            number_text.push_back(CH_MINUS);
        shape = shape_t'($urandom_range(0, 5));
        case (shape)
            SH_INF:
            begin
                number_text.push_back(CH_I);
                number_text.push_back(CH_N);
                number_text.push_back(CH_F);
            end
            SH_ZEROS_DIGITS:
            begin
                repeat ($urandom_range(1, 3)) number_text.push_back(CH_0);
                push_digits($urandom_range(1, 3));
            end
            SH_DIGITS:
            begin
                number_text.push_back(CH_1 + 8'($urandom_range(0, 8)));
                push_digits($urandom_range(0, 3));
            end
            SH_FRACTION:
            begin
                push_digits($urandom_range(1, 3));
                number_text.push_back(CH_DOT);
                push_digits($urandom_range(0, 3));
            end
            SH_LEADING_DOT:
            begin
                number_text.push_back(CH_DOT);
                push_digits($urandom_range(0, 3));
            end
            default:
                repeat ($urandom_range(1, 3)) number_text.push_back(CH_0);
        endcase
        if (shape != SH_INF && $urandom_range(0, 1) == 1)
        begin
            number_text.push_back($urandom_range(0, 1) ? CH_LC_E : CH_UC_E);
            case ($urandom_range(0, 2))
                0: number_text.push_back(CH_PLUS);
                1: number_text.push_back(CH_MINUS);
                default: ;
            endcase
            push_digits($urandom_range(0, 3));
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) number_text.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
            number_text[$urandom_range(0, number_text.size() - 1)] = 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] noise_char();
        string pool;
        pool = "-+.eEinf0123456789";
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // ---------------- tests ----------------

    task test_special_cases();
        gaps_on = 1'b1;
        send_string("-");
        send_string("ix");
        send_string("in");
        send_string("-inf");
        send_string("x");
        send_string("00");
        send_string(".e");
        send_string("9.1.");
        send_string("E+");
        number_text = {CH_0, 8'hFF};
        send_number();
        number_text = {8'h00};
        send_number();
    endtask

    task test_backpressure();
        gaps_on = 1'b0;
        hold_request = 1'b1;
        repeat (8)
        begin
            build_wellformed();
            send_number();
        end
        gaps_on = 1'b1;
    endtask

    task test_random_wellformed();
        int start;
        start = chars_sent;
        while (chars_sent - start < 250)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            build_wellformed();
            send_number();
        end
    endtask

    task test_random_noise();
        int start;
        start = chars_sent;
        while (chars_sent - start < 60)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            number_text.delete();
            repeat ($urandom_range(1, 5)) number_text.push_back(noise_char());
            send_number();
        end
    endtask

    initial begin
        clear_parser();
        rst_n        = 1'b0;
        text.valid   = 1'b0;
        text.in_byte = 8'h00;
        text.last_in = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_backpressure();
        test_random_wellformed();
        test_random_noise();

        text.valid <= 1'b0;
        while (expected_json.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (json_errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
